// File: rtl/clg_pkg.sv
package clg_pkg;

  // Default number of stop slots
  localparam int unsigned MaxStopsDef = 8;

  // Channel and color widths
  localparam int unsigned ChanW  = 16;
  localparam int unsigned ColorW = 4 * ChanW;

  // Command codes carried in tuser
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_e;

endpackage

// File: rtl/color_gradient_lookup.sv
// Multi-stop linear color gradient lookup.
// s_axis carries one transaction per command. tuser[0] is the command:
// lookup or stop write. A stop write loads position and RGBA color of one
// slot and gives no result; a slot beyond the table is ignored. A lookup
// gives one m_axis transaction with the blended RGBA color.
// cfg_valid_i/cfg_data_i set the number of stops searched (0 acts as 1,
// values above the table size saturate); write it only while idle.
// A lookup passes from acceptance to m_axis_tvalid through the search,
// weight setup, 16 divider stages (one quotient bit each), multiply and
// sum stages. One transaction is accepted per cycle while the output is not
// stalled; a write may follow a lookup in the next cycle without disturbing it.
// The pipeline moves as one: when the receiver holds m_axis_tready low
// while a result is waiting, s_axis_tready drops and every stage holds.
// Reset clears all valid bits and sets the stop count to one. Stop contents
// are undefined until written; no clearing pass runs.
module color_gradient_lookup
  import clg_pkg::*;
#(
  parameter int unsigned MaxStops = MaxStopsDef,
  localparam int unsigned AddrW = (MaxStops > 1) ? $clog2(MaxStops) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // index[15:0] slot[18:16] stop_position[34:19] stop_red[50:35]
  // stop_green[66:51] stop_blue[82:67] stop_alpha[98:83], zero fill above
  input  logic [103:0]  s_axis_tdata,
  // command[0]
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // red[15:0] green[31:16] blue[47:32] alpha[63:48]
  output logic [63:0]   m_axis_tdata
);

  localparam int unsigned NW = $clog2(MaxStops + 1);

  logic en;
  logic in_acc;

  // Input fields
  logic [15:0] in_index;
  logic [2:0]  in_slot;
  logic [15:0] in_pos;
  logic [ColorW-1:0] in_color;
  cmd_e        in_cmd;

  assign in_index = s_axis_tdata[15:0];
  assign in_slot  = s_axis_tdata[18:16];
  assign in_pos   = s_axis_tdata[34:19];
  assign in_color = {s_axis_tdata[50:35], s_axis_tdata[66:51],
                     s_axis_tdata[82:67], s_axis_tdata[98:83]};
  assign in_cmd   = cmd_e'(s_axis_tuser[0]);

  // Whole pipeline advances unless a result is stuck at the output
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  // Stop count register
  logic [3:0] stops_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_q <= 4'd1;
    end else if (cfg_valid_i) begin
      stops_q <= cfg_data_i;
    end
  end

  logic [NW-1:0] n_eff;
  always_comb begin
    if (stops_q == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(stops_q) > MaxStops) begin
      n_eff = NW'(MaxStops);
    end else begin
      n_eff = NW'(stops_q);
    end
  end

  // Stop writes
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  assign wr_en   = in_acc && (in_cmd == CMD_WRITE) && (32'(in_slot) < MaxStops);
  assign wr_addr = AddrW'(in_slot);

  logic [15:0] pos_q [MaxStops];
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_q[wr_addr] <= in_pos;
    end
  end

  // Search: compare every stop, pick the first one above the index
  logic [MaxStops-1:0] hit;
  logic [MaxStops-1:0] first;
  logic [AddrW-1:0]    k_bin;
  logic [15:0]         pos_hi;
  logic [15:0]         pos_lo;
  always_comb begin
    for (int k = 0; k < MaxStops; k++) begin
      hit[k] = (k < 32'(n_eff)) && (pos_q[k] > in_index);
    end
    first  = hit & (~hit + 1'b1);
    k_bin  = '0;
    pos_hi = '0;
    pos_lo = '0;
    for (int k = 0; k < MaxStops; k++) begin
      if (first[k]) begin
        k_bin  = k_bin | AddrW'(k);
        pos_hi = pos_hi | pos_q[k];
      end
      if (k + 1 < MaxStops) begin
        if (first[k+1]) begin
          pos_lo = pos_lo | pos_q[k];
        end
      end
    end
  end

  // Stage 1: addresses and positions of the bracketing stops
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_hi_q, s1_lo_q;
  logic [15:0]      s1_phi_q, s1_plo_q, s1_idx_q;
  logic             s1_flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_acc && (in_cmd == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q <= in_index;
      s1_phi_q <= pos_hi;
      s1_plo_q <= pos_lo;
      if (hit == '0) begin
        s1_hi_q   <= AddrW'(n_eff - 1'b1);
        s1_lo_q   <= AddrW'(n_eff - 1'b1);
        s1_flat_q <= 1'b1;
      end else if (first[0]) begin
        s1_hi_q   <= '0;
        s1_lo_q   <= '0;
        s1_flat_q <= 1'b1;
      end else begin
        s1_hi_q   <= k_bin;
        s1_lo_q   <= k_bin - 1'b1;
        s1_flat_q <= 1'b0;
      end
    end
  end

  // Color table, read while the item moves into stage 2
  logic [ColorW-1:0] col_hi, col_lo;
  clg_ram #(
    .Width(ColorW),
    .Depth(MaxStops)
  ) u_colors (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (in_color),
    .re_i     (en),
    .raddr_a_i(s1_hi_q),
    .raddr_b_i(s1_lo_q),
    .rdata_a_o(col_hi),
    .rdata_b_o(col_lo)
  );

  // Stage 2: dividend and divisor; a flat item divides 0 by 1
  logic        s2_valid_q;
  logic [15:0] s2_num_q, s2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s1_flat_q) begin
        s2_num_q <= '0;
        s2_den_q <= 16'd1;
      end else begin
        s2_num_q <= s1_idx_q - s1_plo_q;
        s2_den_q <= s1_phi_q - s1_plo_q;
      end
    end
  end

  // Weight division
  logic                dv_valid;
  logic [15:0]         dv_w;
  logic [2*ColorW-1:0] dv_side;

  clg_divider #(
    .W    (16),
    .SideW(2 * ColorW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s2_valid_q),
    .num_i  (s2_num_q),
    .den_i  (s2_den_q),
    .side_i ({col_hi, col_lo}),
    .valid_o(dv_valid),
    .quo_o  (dv_w),
    .side_o (dv_side)
  );

  // Multiply stage: both products per channel
  logic             mu_valid_q;
  logic [32:0]      mu_hi_q [4];
  logic [32:0]      mu_lo_q [4];
  logic [16:0]      w_inv;
  logic [ChanW-1:0] ch_hi [4];
  logic [ChanW-1:0] ch_lo [4];
  assign w_inv = 17'h10000 - {1'b0, dv_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_valid_q <= 1'b0;
    end else if (en) begin
      mu_valid_q <= dv_valid;
    end
  end

  // Split the carried colors into channels, red first
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ch_hi[c] = dv_side[2*ColorW-1-ChanW*c -: ChanW];
      ch_lo[c] = dv_side[ColorW-1-ChanW*c -: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        mu_hi_q[c] <= 33'(ch_hi[c]) * 33'(dv_w);
        mu_lo_q[c] <= 33'(ch_lo[c]) * 33'(w_inv);
      end
    end
  end

  // Sum and output register
  logic [63:0] out_data_q;
  logic [33:0] ch_sum [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mu_valid_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ch_sum[c] = {1'b0, mu_hi_q[c]} + {1'b0, mu_lo_q[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        out_data_q[ChanW*c +: ChanW] <= ch_sum[c][31:16];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/clg_ram.sv
module clg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read returns the old contents when read and write hit the same entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/clg_divider.sv
// Restoring divider, one quotient bit per stage. Requires num_i < den_i,
// so the quotient of (num_i << W) / den_i fits in W bits.
module clg_divider #(
  parameter int unsigned W     = 16,
  parameter int unsigned SideW = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [W-1:0]     quo_o,
  output logic [SideW-1:0] side_o
);

  // Stage registers; entry s holds the item after s+1 quotient bits
  logic             valid_q [W];
  logic [W-1:0]     rem_q   [W];
  logic [W-1:0]     den_q   [W];
  logic [W-1:0]     quo_q   [W];
  logic [SideW-1:0] side_q  [W];

  // Inputs of each stage and their next values
  logic             valid_in [W];
  logic [W-1:0]     rem_in   [W];
  logic [W-1:0]     den_in   [W];
  logic [W-1:0]     quo_in   [W];
  logic [SideW-1:0] side_in  [W];
  logic [W-1:0]     rem_d    [W];
  logic [W-1:0]     quo_d    [W];

  // Stage zero takes the input itself, later stages the previous register
  always_comb begin
    valid_in[0] = valid_i;
    rem_in[0]   = num_i;
    den_in[0]   = den_i;
    quo_in[0]   = '0;
    side_in[0]  = side_i;
    for (int s = 1; s < W; s++) begin
      valid_in[s] = valid_q[s-1];
      rem_in[s]   = rem_q[s-1];
      den_in[s]   = den_q[s-1];
      quo_in[s]   = quo_q[s-1];
      side_in[s]  = side_q[s-1];
    end
  end

  // Shift in a zero, subtract when the divisor fits
  always_comb begin
    logic [W:0] shifted;
    logic [W:0] diff;
    logic       take;
    for (int s = 0; s < W; s++) begin
      shifted  = {rem_in[s], 1'b0};
      diff     = shifted - {1'b0, den_in[s]};
      take     = shifted >= {1'b0, den_in[s]};
      rem_d[s] = take ? diff[W-1:0] : shifted[W-1:0];
      quo_d[s] = {quo_in[s][W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < W; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < W; s++) begin
        valid_q[s] <= valid_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < W; s++) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        quo_q[s]  <= quo_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = valid_q[W-1];
  assign quo_o   = quo_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// File: tb/color_gradient_lookup_test.sv
module color_gradient_lookup_test;
  import clg_pkg::*;

  localparam int unsigned NumSlots  = 8;
  localparam int unsigned Latency   = 19;
  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgba_t;

  // Result scoreboard: keeps a gradient table and predicts blended colors
  class gradient_scoreboard;
    logic [15:0] stop_pos[NumSlots];
    rgba_t       stop_rgba[NumSlots];
    logic [3:0]  stops_in_use;
    rgba_t       pending_colors[$];
    int          errors;

    function new();
      stops_in_use = 4'd1;
      errors = 0;
      foreach (stop_pos[k]) begin
        stop_pos[k] = '0;
        stop_rgba[k] = '0;
      end
    endfunction

    function rgba_t blend(logic [15:0] idx);
      int unsigned n, k, prev, w;
      rgba_t hi, lo, res;
      prev = 0;
      n = stops_in_use;
      if (n < 1) n = 1;
      if (n > NumSlots) n = NumSlots;
      for (k = 0; k < n; k++) begin
        if (stop_pos[k] > idx) begin
          hi = stop_rgba[k];
          if (k == 0) return hi;
          lo = stop_rgba[k-1];
          w = ((idx - prev) << 16) / (stop_pos[k] - prev);
          res.red   = 16'((64'(hi.red) * w + 64'(lo.red) * (65536 - w)) >> 16);
          res.green = 16'((64'(hi.green) * w + 64'(lo.green) * (65536 - w)) >> 16);
          res.blue  = 16'((64'(hi.blue) * w + 64'(lo.blue) * (65536 - w)) >> 16);
          res.alpha = 16'((64'(hi.alpha) * w + 64'(lo.alpha) * (65536 - w)) >> 16);
          return res;
        end
        prev = stop_pos[k];
      end
      return stop_rgba[n-1];
    endfunction

    // Note an accepted input transaction
    function void note_input(cmd_e cmd, logic [103:0] data);
      if (cmd == CMD_WRITE) begin
        stop_pos[data[18:16]] = data[34:19];
        stop_rgba[data[18:16]] = {data[98:83], data[82:67], data[66:51], data[50:35]};
      end else begin
        pending_colors.push_back(blend(data[15:0]));
      end
    endfunction

    // Check one accepted result transaction
    function void check_result(rgba_t got);
      rgba_t exp_c;
      if (pending_colors.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_c = pending_colors.pop_front();
      if (got.red !== exp_c.red) begin
        $error("red: expected %h actual %h", exp_c.red, got.red); errors++;
      end
      if (got.green !== exp_c.green) begin
        $error("green: expected %h actual %h", exp_c.green, got.green); errors++;
      end
      if (got.blue !== exp_c.blue) begin
        $error("blue: expected %h actual %h", exp_c.blue, got.blue); errors++;
      end
      if (got.alpha !== exp_c.alpha) begin
        $error("alpha: expected %h actual %h", exp_c.alpha, got.alpha); errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [3:0]    cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;

  gradient_scoreboard sb;
  bit    rx_random = 1'b0;
  bit    rx_hold = 1'b0;
  int    idle_cycles = 0;
  int    lookups_sent = 0;
  int    writes_sent = 0;

  always #5 clk_i = ~clk_i;

  color_gradient_lookup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Sample accepted transactions and run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(cmd_e'(s_axis_tuser[0]), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired with %0d results outstanding",
                 sb.pending_colors.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: ready with random stall bursts, or a long hold
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_random && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and wait until accepted
  task automatic send_item(cmd_e cmd, logic [103:0] data, bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_WRITE) writes_sent++;
    else lookups_sent++;
  endtask

  task automatic write_stop(int unsigned slot, logic [15:0] pos, rgba_t c, bit gaps);
    logic [103:0] d;
    d = '0;
    d[18:16] = slot[2:0];
    d[34:19] = pos;
    d[50:35] = c.red;
    d[66:51] = c.green;
    d[82:67] = c.blue;
    d[98:83] = c.alpha;
    d[15:0]  = 16'($urandom);
    send_item(CMD_WRITE, d, gaps);
  endtask

  task automatic look_up(logic [15:0] idx, bit gaps);
    logic [103:0] d;
    // unused fields carry noise
    d = {8'h00, 32'($urandom), 32'($urandom), 16'($urandom), idx};
    send_item(CMD_LOOKUP, d, gaps);
  endtask

  // Wait for all results, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_colors.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic set_stop_count(logic [3:0] n);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.stops_in_use = n;
  endtask

  function automatic rgba_t rand_color();
    return rgba_t'({32'($urandom), 32'($urandom)});
  endfunction

  // Write all slots with ascending random positions, sometimes with edge values
  task automatic load_table(bit gaps);
    logic [15:0] p[$];
    for (int k = 0; k < NumSlots; k++) p.push_back(16'($urandom));
    p.sort();
    if ($urandom_range(0, 3) == 0) p[0] = 16'h0000;
    if ($urandom_range(0, 3) == 0) p[NumSlots-1] = 16'hffff;
    if ($urandom_range(0, 4) == 0) p[2] = p[1];
    for (int k = 0; k < NumSlots; k++) write_stop(k, p[k], rand_color(), gaps);
  endtask

  // Lookup index biased toward stop positions and the extremes
  function automatic logic [15:0] pick_index(int unsigned n);
    int unsigned s, r;
    s = $urandom_range(0, n - 1);
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hffff;
    if (r < 4) return sb.stop_pos[s];
    if (r < 6) return sb.stop_pos[s] - 16'd1;
    return 16'($urandom);
  endfunction

  initial begin
    logic [3:0] counts[$];
    int unsigned n;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full table with extreme values, stops at reset count of one
    write_stop(0, 16'h4000, rgba_t'(64'hffff_ffff_ffff_ffff), 0);
    write_stop(1, 16'h8000, rgba_t'(64'h0000_0000_0000_0000), 0);
    write_stop(2, 16'h8000, rgba_t'(64'h1234_5678_9abc_def0), 0);
    write_stop(3, 16'hc000, rgba_t'(64'hffff_0000_ffff_0000), 0);
    write_stop(4, 16'hfffe, rgba_t'(64'h0001_ffff_0001_ffff), 0);
    write_stop(5, 16'hffff, rgba_t'(64'haaaa_5555_aaaa_5555), 0);
    write_stop(6, 16'h0010, rgba_t'(64'h5555_aaaa_5555_aaaa), 0); // out of order
    write_stop(7, 16'hffff, rgba_t'(64'h8000_8000_8000_8000), 0);
    look_up(16'h0000, 0);
    look_up(16'hffff, 0);
    drain();
    set_stop_count(4'd0);  // acts as one stop
    look_up(16'h3fff, 0);
    look_up(16'h5000, 0);
    drain();
    set_stop_count(4'd15); // saturates to the full table
    look_up(16'h0000, 0);  // below first stop
    look_up(16'h4000, 0);  // exactly on a stop
    look_up(16'h7fff, 0);
    look_up(16'h8000, 0);  // duplicate positions
    look_up(16'hbfff, 0);
    look_up(16'hfffd, 0);
    look_up(16'hfffe, 0);
    look_up(16'hffff, 0);  // on the last stop, none above it
    drain();
    set_stop_count(4'd8);
    look_up(16'h1234, 0);
    look_up(16'hffff, 0);

    // Long receiver hold while the sender keeps offering lookups
    fork
      begin
        rx_hold = 1'b1;
        repeat (200) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 60; i++) look_up(16'($urandom), 0);
    join
    drain();

    // Random phases over several stop counts
    rx_random = 1'b1;
    counts = '{4'd2, 4'd8, 4'd3, 4'd1, 4'd15, 4'd5, 4'd0, 4'd7, 4'd8, 4'd4};
    foreach (counts[c]) begin
      set_stop_count(counts[c]);
      n = (counts[c] == 0) ? 1 : (counts[c] > NumSlots ? NumSlots : counts[c]);
      for (int i = 0; i < 170; i++) begin
        if ($urandom_range(0, 39) == 0)
          load_table(1);
        else if ($urandom_range(0, 29) == 0)
          write_stop($urandom_range(0, NumSlots - 1), 16'($urandom), rand_color(), 1);
        else
          look_up(pick_index(n), 1);
      end
      // sender pauses until every result is back
      drain();
    end

    // Final stretch without idling
    rx_random = 1'b0;
    load_table(0);
    for (int i = 0; i < 200; i++) look_up(pick_index(NumSlots), 0);
    drain();

    $display("Covered %0d lookups and %0d stop writes over stop counts 0 to 15,",
             lookups_sent, writes_sent);
    $display("with random stalls on both sides and a long receiver hold.");
    if (sb.errors == 0 && sb.pending_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
